// File: src/ipv4hv_pkg.sv
// Package: shared types and constants for the IPv4 header validator.
package ipv4hv_pkg;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT      = 3'd0,
      VERDICT_BAD_VERSION = 3'd1,
      VERDICT_SHORT_HDR   = 3'd2,
      VERDICT_BAD_CSUM    = 3'd3,
      VERDICT_NOT_ADDR    = 3'd4,
      VERDICT_IGMP        = 3'd5,
      VERDICT_UNSUPPORTED = 3'd6
   } verdict_type;

   typedef enum logic [1:0] {
      CLASS_UDP  = 2'd0,
      CLASS_TCP  = 2'd1,
      CLASS_ICMP = 2'd2,
      CLASS_NONE = 2'd3
   } proto_class_type;

   localparam logic [3:0]  IP_VERSION     = 4'd4;
   localparam logic [3:0]  MIN_IHL        = 4'd5;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_IGMP     = 8'd2;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;
   localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;

   // header word positions
   localparam logic [4:0] POS_TOTAL_LEN = 5'd1;
   localparam logic [4:0] POS_TTL_PROTO = 5'd4;
   localparam logic [4:0] POS_SRC_HI    = 5'd6;
   localparam logic [4:0] POS_SRC_LO    = 5'd7;
   localparam logic [4:0] POS_DST_HI    = 5'd8;
   localparam logic [4:0] POS_DST_LO    = 5'd9;

endpackage

// File: src/ipv4hv_req_if.sv
// Interface: header word input channel.
interface ipv4hv_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] word;
   logic        first;
   logic        csum_offloaded;
   logic [15:0] offload_csum;

   modport source (output valid, word, first, csum_offloaded, offload_csum, input ready);
   modport sink   (input valid, word, first, csum_offloaded, offload_csum, output ready);
endinterface

// File: src/ipv4hv_rsp_if.sv
// Interface: per-packet verdict output channel.
interface ipv4hv_rsp_if import ipv4hv_pkg::*; ;
   logic            valid;
   logic            ready;
   verdict_type     verdict;
   proto_class_type proto_class;
   logic [7:0]      protocol;
   logic [15:0]     payload_length;
   logic [31:0]     src_addr;
   logic [31:0]     dst_addr;
   logic [7:0]      ttl;

   modport source (output valid, verdict, proto_class, protocol, payload_length,
                   src_addr, dst_addr, ttl, input ready);
   modport sink   (input valid, verdict, proto_class, protocol, payload_length,
                   src_addr, dst_addr, ttl, output ready);
endinterface

// File: src/ipv4_header_validator_core.sv
// IPv4 header validator: checks a header streamed one 16-bit word at a time.
//
// req_chan carries one header word per handshake, with first set on the first
// word of each packet; csum_offloaded and offload_csum are sampled at that word.
// rsp_chan carries at most one verdict word per packet: version and header
// length verdicts follow the first word, all others follow the last header word.
// Words after a verdict are ignored until the next first word; a first word that
// arrives mid-header drops the unfinished header with no verdict.
// csr_we/csr_wdata write the local address; write it only while idle.
// The verdict is registered and valid in the cycle after the word that decides it.
// Throughput: one word per cycle unless a held verdict stalls rsp_chan; each word
// needs one end-around-carry add and field capture; one output stage holds the verdict.
// Reset clears the packet tracking, the output valid and the local address.
// When rsp_chan stalls with a verdict held, req_chan ready stays low until the
// held verdict is taken; a verdict taken in a cycle frees the input that cycle.
module ipv4_header_validator_core
   import ipv4hv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   ipv4hv_req_if.sink   req_chan,
   ipv4hv_rsp_if.source rsp_chan
);

   logic [31:0] local_addr_ff;

   logic        active_ff, active_in;
   logic [4:0]  word_index_ff, word_index_in;
   logic [4:0]  header_words_ff, header_words_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [7:0]  ttl_value_ff, ttl_value_in;
   logic [7:0]  proto_value_ff, proto_value_in;
   logic [31:0] source_value_ff, source_value_in;
   logic [31:0] dest_value_ff, dest_value_in;
   logic        offload_flag_ff, offload_flag_in;
   logic [15:0] offload_value_ff, offload_value_in;

   logic            rsp_valid_ff;
   verdict_type     verdict_ff, verdict_in;
   proto_class_type class_ff, class_in;
   logic [7:0]      protocol_ff, protocol_in;
   logic [15:0]     plen_ff, plen_in;
   logic [31:0]     src_ff, src_in;
   logic [31:0]     dst_ff, dst_in;
   logic [7:0]      ttl_ff, ttl_in;
   logic            result_in;

   logic        fire;
   logic [3:0]  version;
   logic [3:0]  ihl;
   logic [16:0] sum_wide;
   logic [15:0] sum_fold;
   logic [5:0]  hdr_bytes;
   logic        csum_bad;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;

   assign version   = req_chan.word[15:12];
   assign ihl       = req_chan.word[11:8];
   assign sum_wide  = {1'b0, running_sum_ff} + {1'b0, req_chan.word};
   assign sum_fold  = sum_wide[15:0] + {15'd0, sum_wide[16]};
   assign hdr_bytes = {header_words_ff, 1'b0};

   always_comb begin
      active_in        = active_ff;
      word_index_in    = word_index_ff;
      header_words_in  = header_words_ff;
      running_sum_in   = running_sum_ff;
      total_length_in  = total_length_ff;
      ttl_value_in     = ttl_value_ff;
      proto_value_in   = proto_value_ff;
      source_value_in  = source_value_ff;
      dest_value_in    = dest_value_ff;
      offload_flag_in  = offload_flag_ff;
      offload_value_in = offload_value_ff;

      result_in   = 1'b0;
      verdict_in  = VERDICT_ACCEPT;
      class_in    = CLASS_NONE;
      protocol_in = 8'd0;
      plen_in     = 16'd0;
      src_in      = 32'd0;
      dst_in      = 32'd0;
      ttl_in      = 8'd0;
      csum_bad    = 1'b0;

      if (fire) begin
         if (req_chan.first) begin
            active_in = 1'b0;
            if (version != IP_VERSION) begin
               result_in  = 1'b1;
               verdict_in = VERDICT_BAD_VERSION;
            end else if (ihl < MIN_IHL) begin
               result_in  = 1'b1;
               verdict_in = VERDICT_SHORT_HDR;
            end else begin
               active_in        = 1'b1;
               header_words_in  = {ihl, 1'b0};
               word_index_in    = 5'd1;
               running_sum_in   = req_chan.word;
               offload_flag_in  = req_chan.csum_offloaded;
               offload_value_in = req_chan.offload_csum;
               total_length_in  = 16'd0;
               ttl_value_in     = 8'd0;
               proto_value_in   = 8'd0;
               source_value_in  = 32'd0;
               dest_value_in    = 32'd0;
            end
         end else if (active_ff) begin
            running_sum_in = sum_fold;
            unique case (word_index_ff)
               POS_TOTAL_LEN: total_length_in = req_chan.word;
               POS_TTL_PROTO: begin
                  ttl_value_in   = req_chan.word[15:8];
                  proto_value_in = req_chan.word[7:0];
               end
               POS_SRC_HI: source_value_in[31:16] = req_chan.word;
               POS_SRC_LO: source_value_in[15:0]  = req_chan.word;
               POS_DST_HI: dest_value_in[31:16]   = req_chan.word;
               POS_DST_LO: dest_value_in[15:0]    = req_chan.word;
               default: ;
            endcase
            word_index_in = word_index_ff + 5'd1;

            if (word_index_in == header_words_ff) begin
               active_in   = 1'b0;
               result_in   = 1'b1;
               protocol_in = proto_value_in;
               src_in      = source_value_in;
               dst_in      = dest_value_in;
               ttl_in      = ttl_value_in;
               plen_in     = (total_length_in > {10'd0, hdr_bytes}) ?
                             total_length_in - {10'd0, hdr_bytes} : 16'd0;
               csum_bad    = offload_flag_ff ? (offload_value_ff != 16'd0)
                                             : (running_sum_in != CSUM_GOOD);
               priority if (csum_bad) begin
                  verdict_in = VERDICT_BAD_CSUM;
               end else if (dest_value_in != local_addr_ff &&
                            dest_value_in != BROADCAST_ADDR) begin
                  verdict_in = VERDICT_NOT_ADDR;
               end else if (proto_value_in == PROTO_UDP) begin
                  class_in = CLASS_UDP;
               end else if (proto_value_in == PROTO_TCP) begin
                  class_in = CLASS_TCP;
               end else if (proto_value_in == PROTO_ICMP) begin
                  class_in = CLASS_ICMP;
               end else if (proto_value_in == PROTO_IGMP) begin
                  verdict_in = VERDICT_IGMP;
               end else begin
                  verdict_in = VERDICT_UNSUPPORTED;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff   <= 32'd0;
         active_ff       <= 1'b0;
         word_index_ff   <= 5'd0;
         header_words_ff <= 5'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            local_addr_ff <= csr_wdata;
         end
         active_ff       <= active_in;
         word_index_ff   <= word_index_in;
         header_words_ff <= header_words_in;
         if (result_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      running_sum_ff   <= running_sum_in;
      total_length_ff  <= total_length_in;
      ttl_value_ff     <= ttl_value_in;
      proto_value_ff   <= proto_value_in;
      source_value_ff  <= source_value_in;
      dest_value_ff    <= dest_value_in;
      offload_flag_ff  <= offload_flag_in;
      offload_value_ff <= offload_value_in;
      if (result_in) begin
         verdict_ff  <= verdict_in;
         class_ff    <= class_in;
         protocol_ff <= protocol_in;
         plen_ff     <= plen_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         ttl_ff      <= ttl_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.verdict        = verdict_ff;
   assign rsp_chan.proto_class    = class_ff;
   assign rsp_chan.protocol       = protocol_ff;
   assign rsp_chan.payload_length = plen_ff;
   assign rsp_chan.src_addr       = src_ff;
   assign rsp_chan.dst_addr       = dst_ff;
   assign rsp_chan.ttl            = ttl_ff;

endmodule
